### rtl/omni_wheel_mix_smoother_unit_macros.svh
// Assertion macros for the omni wheel mixer.
// Each check is compiled out when SYNTHESIS is defined.
`ifndef OMNI_WHEEL_MIX_SMOOTHER_UNIT_MACROS_SVH
`define OMNI_WHEEL_MIX_SMOOTHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OWMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owms: same-cycle check failed");
// next-cycle implication
`define OWMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owms: next-cycle check failed");
`else
`define OWMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OWMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/owms_pkg.sv
package owms_pkg;

    localparam int PW_W    = 16;          // wheel power, Q8.8
    localparam int STK_W   = 8;           // stick axis
    localparam int OP_W    = 2;
    localparam int CFG_W   = 9;
    localparam int FRAC_W  = 8;
    localparam int A_W     = PW_W + 1;    // multiplicand: widest is target minus wheel
    localparam int B_W     = 16;          // multiplier, serially consumed
    localparam int P_W     = 26;          // product
    localparam int RND_W   = P_W - FRAC_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_LSB = 2;

    typedef logic signed [PW_W-1:0] t_pow;

    typedef enum logic [OP_W-1:0] {
        OP_NORMAL = 2'd0,
        OP_DRIFT  = 2'd1,
        OP_ROTATE = 2'd2,
        OP_PARK   = 2'd3
    } t_op;

    typedef enum logic {
        REG_SMOOTHING = 1'b0,
        REG_TURN_GAIN = 1'b1
    } t_reg;

    localparam logic [CFG_W-1:0] SMOOTH_RST = 9'd64;
    localparam logic [CFG_W-1:0] GAIN_RST   = 9'd128;
    localparam logic [CFG_W-1:0] LAMBDA_ONE = 9'd256;

    localparam logic [B_W-1:0] INV_SQRT2_Q16 = 16'd46341;

    localparam t_pow POW_MAX = 16'sh7FFF;
    localparam t_pow POW_MIN = 16'sh8000;

    localparam logic signed [P_W-1:0] WHEEL_MAX = P_W'(32767);
    localparam logic signed [P_W-1:0] WHEEL_MIN = -P_W'(32768);
    localparam logic signed [P_W-1:0] VEC_MAX   = P_W'(25600);
    localparam logic signed [P_W-1:0] VEC_MIN   = -P_W'(25600);
    localparam logic signed [P_W-1:0] RND_HALF  = P_W'(128);

    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic [B_W-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic signed [P_W-1:0] p;
    } t_mul_rsp;

    // round half up, drop FRAC_W fraction bits
    function automatic logic signed [RND_W-1:0] round_frac(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] t;
        t = v + RND_HALF;
        return t[P_W-1:FRAC_W];
    endfunction

    function automatic t_pow sat_pow(input logic signed [P_W-1:0] v);
        t_pow r;
        if (v > WHEEL_MAX) begin
            r = POW_MAX;
        end else if (v < WHEEL_MIN) begin
            r = POW_MIN;
        end else begin
            r = v[PW_W-1:0];
        end
        return r;
    endfunction

    // +/-100.0 limit on the rotated stick vector
    function automatic t_pow clamp_vec(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] c;
        if (v > VEC_MAX) begin
            c = VEC_MAX;
        end else if (v < VEC_MIN) begin
            c = VEC_MIN;
        end else begin
            c = v;
        end
        return c[PW_W-1:0];
    endfunction

endpackage

### rtl/owms_if.sv
interface owms_cmd_if;
    import owms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [STK_W-1:0] stick_x;
    logic signed [STK_W-1:0] stick_y;

    modport source (output valid, output opcode, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input opcode, input stick_x, input stick_y, output ready);
endinterface

interface owms_pow_if;
    import owms_pkg::*;

    logic valid;
    logic ready;
    t_pow power_a;
    t_pow power_b;
    t_pow power_c;
    t_pow power_d;

    modport source (output valid, output power_a, output power_b, output power_c,
                    output power_d, input ready);
    modport sink   (input valid, input power_a, input power_b, input power_c,
                    input power_d, output ready);
endinterface

### rtl/omni_wheel_mix_smoother_unit.sv
// A new command is taken only in idle, once the previous one is handed to the
//   output register. Each multiply runs on the shared bit-serial multiplier, which
//   stops once the remaining bits of its multiplier are zero. The output register
//   lets the next command in while a result beat waits.
// Reset (synchronous, active low): wheel powers zero, lambda 64, turn gain 128.
`include "omni_wheel_mix_smoother_unit_macros.svh"

module omni_wheel_mix_smoother_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    owms_cmd_if.sink                     i_cmd,
    owms_pow_if.source                   o_pow,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owms_pkg::APB_AW-1:0]  paddr,
    input  logic [owms_pkg::APB_DW-1:0]  pwdata,
    output logic [owms_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import owms_pkg::*;

    // Sequencer: each command walks through the states it needs. Every
    // multiplying state launches one job on the serial multiplier and waits
    // for its done flag.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TGT1   = 6'b000010,   // first rotated component  (x - y) / sqrt2
        S_TGT2   = 6'b000100,   // second rotated component (-x - y) / sqrt2
        S_GAIN   = 6'b001000,   // rotate mode: gain * x
        S_SMOOTH = 6'b010000,   // one wheel per pass, A..D
        S_OUT    = 6'b100000    // hand result to the output register
    } t_state;

    localparam logic signed [STK_W-1:0] STK_MIN = {1'b1, {(STK_W-1){1'b0}}};

    t_state                  r_state, n_state;
    logic                    r_launched, n_launched;
    t_op                     r_op, n_op;
    logic signed [STK_W-1:0] r_x, n_x;
    logic signed [STK_W-1:0] r_y, n_y;
    t_pow                    r_v1, n_v1;
    t_pow [3:0]              r_t, n_t;       // targets
    t_pow [3:0]              r_w, n_w;       // smoothed wheel powers
    logic [1:0]              r_idx, n_idx;
    logic                    r_ovalid, n_ovalid;
    t_pow [3:0]              r_out, n_out;

    logic [CFG_W-1:0]        cfg_lambda;
    logic [CFG_W-1:0]        cfg_gain;
    logic [CFG_W-1:0]        lam;

    t_mul_req                mul_req;
    t_mul_rsp                mul_rsp;

    // operand and result helpers
    logic signed [A_W-1:0]   xe, ye, s_1, s_2, err;
    t_pow                    t_cur, w_cur;
    logic signed [RND_W-1:0] rnd;
    logic signed [P_W-1:0]   rnd_ext, nw, neg_p;
    t_pow                    vec_c, g_pos, g_neg;
    t_op                     cmd_op;
    logic signed [STK_W-1:0] cmd_negx;
    t_pow                    drift_p, drift_n;

    owms_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_lambda (cfg_lambda),
        .o_gain   (cfg_gain)
    );

    owms_sermul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // lambda above 1.0 acts as 1.0
    assign lam = (cfg_lambda > LAMBDA_ONE) ? LAMBDA_ONE : cfg_lambda;

    assign xe  = {{(A_W-STK_W){r_x[STK_W-1]}}, r_x};
    assign ye  = {{(A_W-STK_W){r_y[STK_W-1]}}, r_y};
    assign s_1 = xe - ye;
    assign s_2 = -xe - ye;

    assign t_cur = r_t[r_idx];
    assign w_cur = r_w[r_idx];
    assign err   = {{(A_W-PW_W){t_cur[PW_W-1]}}, t_cur} - {{(A_W-PW_W){w_cur[PW_W-1]}}, w_cur};

    assign rnd     = round_frac(mul_rsp.p);
    assign rnd_ext = {{(P_W-RND_W){rnd[RND_W-1]}}, rnd};
    assign nw      = {{(P_W-PW_W){w_cur[PW_W-1]}}, w_cur} + rnd_ext;
    assign vec_c   = clamp_vec(rnd_ext);
    assign neg_p   = -mul_rsp.p;
    assign g_pos   = sat_pow(mul_rsp.p);
    assign g_neg   = sat_pow(neg_p);

    // drift with y at zero: +/- x as a whole number, -(-128) saturates
    assign cmd_op   = t_op'(i_cmd.opcode);
    assign cmd_negx = -i_cmd.stick_x;
    assign drift_p  = {i_cmd.stick_x, {FRAC_W{1'b0}}};
    assign drift_n  = (i_cmd.stick_x == STK_MIN) ? POW_MAX : {cmd_negx, {FRAC_W{1'b0}}};

    always_comb begin
        n_state    = r_state;
        n_launched = r_launched;
        n_op       = r_op;
        n_x        = r_x;
        n_y        = r_y;
        n_v1       = r_v1;
        n_t        = r_t;
        n_w        = r_w;
        n_idx      = r_idx;
        n_ovalid   = r_ovalid;
        n_out      = r_out;

        // multiplier operands follow the state
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            S_TGT1: begin
                mul_req.a = s_1;
                mul_req.b = INV_SQRT2_Q16;
            end
            S_TGT2: begin
                mul_req.a = s_2;
                mul_req.b = INV_SQRT2_Q16;
            end
            S_GAIN: begin
                mul_req.a = xe;
                mul_req.b = {{(B_W-CFG_W){1'b0}}, cfg_gain};
            end
            S_SMOOTH: begin
                mul_req.a = err;
                mul_req.b = {{(B_W-CFG_W){1'b0}}, lam};
            end
            default: mul_req.a = '0;
        endcase

        if (((r_state == S_TGT1) || (r_state == S_TGT2) || (r_state == S_GAIN) ||
             (r_state == S_SMOOTH)) && !r_launched) begin
            mul_req.start = 1'b1;
            n_launched    = 1'b1;
        end

        if (o_pow.valid && o_pow.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op  = cmd_op;
                    n_x   = i_cmd.stick_x;
                    n_y   = i_cmd.stick_y;
                    n_idx = '0;
                    case (cmd_op)
                        OP_NORMAL: n_state = S_TGT1;
                        OP_DRIFT: begin
                            if (i_cmd.stick_y != '0) begin
                                n_state = S_TGT1;
                            end else begin
                                n_t[0]  = drift_p;
                                n_t[2]  = drift_p;
                                n_t[1]  = drift_n;
                                n_t[3]  = drift_n;
                                n_state = S_SMOOTH;
                            end
                        end
                        OP_ROTATE: n_state = S_GAIN;
                        default: begin
                            n_t     = '0;
                            n_state = S_SMOOTH;
                        end
                    endcase
                end
            end
            S_TGT1: begin
                if (mul_rsp.done) begin
                    n_v1       = vec_c;
                    n_launched = 1'b0;
                    n_state    = S_TGT2;
                end
            end
            S_TGT2: begin
                if (mul_rsp.done) begin
                    n_launched = 1'b0;
                    n_state    = S_SMOOTH;
                    if (r_op == OP_NORMAL) begin
                        n_t[0] = r_v1;
                        n_t[3] = r_v1;
                        n_t[1] = vec_c;
                        n_t[2] = vec_c;
                    end else begin
                        n_t[0] = r_v1;
                        n_t[2] = r_v1;
                        n_t[1] = vec_c;
                        n_t[3] = vec_c;
                    end
                end
            end
            S_GAIN: begin
                if (mul_rsp.done) begin
                    n_t[1]     = g_pos;
                    n_t[2]     = g_pos;
                    n_t[0]     = g_neg;
                    n_t[3]     = g_neg;
                    n_launched = 1'b0;
                    n_state    = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                if (mul_rsp.done) begin
                    n_w[r_idx] = sat_pow(nw);
                    n_launched = 1'b0;
                    n_idx      = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // wait here only while the previous result beat is still held
                if (!r_ovalid || o_pow.ready) begin
                    n_out    = r_w;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_w        <= '0;
            r_idx      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
            r_w        <= n_w;
            r_idx      <= n_idx;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_v1  <= n_v1;
        r_t   <= n_t;
        r_out <= n_out;
    end

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_pow.valid   = r_ovalid;
    assign o_pow.power_a = r_out[0];
    assign o_pow.power_b = r_out[1];
    assign o_pow.power_c = r_out[2];
    assign o_pow.power_d = r_out[3];

    // multiplier is never restarted mid-job
    `OWMS_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, mul_req.start, !mul_rsp.busy)
    // an idle sequencer leaves the multiplier quiet
    `OWMS_ASSERT_IMP(a_idle_mul_quiet, i_clk, i_rst_n, i_cmd.ready, !mul_rsp.busy)
    // an accepted beat always starts work
    `OWMS_ASSERT_NXT(a_accept_runs, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, r_state != S_IDLE)
    // wheel state moves only during smoothing
    `OWMS_ASSERT_NXT(a_wheels_hold, i_clk, i_rst_n, r_state != S_SMOOTH, $stable(r_w))
    // an empty output register is loaded at once
    `OWMS_ASSERT_NXT(a_out_loads, i_clk, i_rst_n, (r_state == S_OUT) && !r_ovalid, r_ovalid)

endmodule

### rtl/owms_cfg.sv
module owms_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owms_pkg::APB_AW-1:0]  paddr,
    input  logic [owms_pkg::APB_DW-1:0]  pwdata,
    output logic [owms_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [owms_pkg::CFG_W-1:0]   o_lambda,
    output logic [owms_pkg::CFG_W-1:0]   o_gain
);
    import owms_pkg::*;

    logic [CFG_W-1:0] r_lambda, n_lambda;
    logic [CFG_W-1:0] r_gain, n_gain;
    t_reg             reg_sel;

    assign reg_sel = t_reg'(paddr[REG_IDX_LSB]);

    always_comb begin
        n_lambda = r_lambda;
        n_gain   = r_gain;
        if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_SMOOTHING: n_lambda = pwdata[CFG_W-1:0];
                REG_TURN_GAIN: n_gain   = pwdata[CFG_W-1:0];
                default:       n_lambda = r_lambda;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= SMOOTH_RST;
            r_gain   <= GAIN_RST;
        end else begin
            r_lambda <= n_lambda;
            r_gain   <= n_gain;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SMOOTHING: prdata = {{(APB_DW-CFG_W){1'b0}}, r_lambda};
            REG_TURN_GAIN: prdata = {{(APB_DW-CFG_W){1'b0}}, r_gain};
            default:       prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_lambda = r_lambda;
    assign o_gain   = r_gain;

endmodule

### rtl/owms_sermul.sv
// Bit-serial shift-add multiplier: signed a times unsigned b, one bit of b
// per cycle, stops as soon as the remaining bits of b are zero.
module owms_sermul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  owms_pkg::t_mul_req i_req,
    output owms_pkg::t_mul_rsp o_rsp
);
    import owms_pkg::*;

    logic                  r_busy, n_busy;
    logic signed [P_W-1:0] r_a, n_a;
    logic [B_W-1:0]        r_b, n_b;
    logic signed [P_W-1:0] r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_a    = {{(P_W-A_W){i_req.a[A_W-1]}}, i_req.a};
            n_b    = i_req.b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = r_a <<< 1;
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_busy && (r_b == '0);
    assign o_rsp.p    = r_acc;

endmodule
